// ----- src/scalar_kalman_filter_top_assert.svh -----
// Assertion macros shared by the filter top and the divider.
`ifndef SCALAR_KALMAN_FILTER_TOP_ASSERT_SVH
`define SCALAR_KALMAN_FILTER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define SKF_ASSERT_NOW(lbl, ck, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define SKF_ASSERT_NEXT(lbl, ck, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/skf_pkg.sv -----
`default_nettype none

package skf_pkg;

  localparam int DATA_W    = 32;
  localparam int GAIN_W    = 17;
  localparam int CFG_IDX_W = 2;
  localparam int STEPS     = 17;
  localparam int CNT_W     = 5;

  // Serial multiplier widths: signed multiplicand, accumulator high half, full product
  localparam int MC_W   = 34;
  localparam int HI_W   = 35;
  localparam int PROD_W = HI_W + GAIN_W;

  // Divider remainder and divisor widths
  localparam int REM_W = 34;
  localparam int DEN_W = 33;

  localparam logic [GAIN_W-1:0] ONE_Q16 = 17'h10000;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEASUREMENT_NOISE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_COV       = 2'd2;

  localparam logic [DATA_W-1:0] RST_PROCESS_NOISE     = 32'd655;
  localparam logic [DATA_W-1:0] RST_MEASUREMENT_NOISE = 32'd65536;
  localparam logic [DATA_W-1:0] RST_INITIAL_COV       = 32'd65536;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_DIV,
    S_GAIN,
    S_MUL,
    S_DONE
  } skf_state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic first;
  } skf_div_ctl_t;

  typedef struct packed {
    logic load;
    logic step;
  } skf_mul_ctl_t;

endpackage

`default_nettype wire

// ----- src/scalar_kalman_filter_top.sv -----
// Scalar Kalman filter, Q16.16. A new measurement is taken only once the last
// one is through: the block predicts the covariance, runs the restoring
// divider that forms the gain one bit per cycle, loads the multipliers, runs
// the two bit-serial multipliers (estimate correction and covariance shrink,
// side by side), rounds, clamps and loads the output register, and returns to
// idle, where the next measurement is taken. The round/clamp step stretches
// while an earlier result still waits in a stalled output register.
// in_stall is low only while the block is idle; the result waits in the
// output register, and a new measurement may be taken while it waits. The
// first measurement after reset loads the estimate and the initial
// covariance. Configuration writes are taken at any time but belong in idle.
`default_nettype none

`include "scalar_kalman_filter_top_assert.svh"

module scalar_kalman_filter_top (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic signed [skf_pkg::DATA_W-1:0]     in_measurement,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic signed      [skf_pkg::DATA_W-1:0]     out_filtered_value,
  output logic             [skf_pkg::DATA_W-1:0]     out_error_covariance,
  output logic             [skf_pkg::GAIN_W-1:0]     out_gain,
  input  wire logic                                  cfg_we,
  input  wire logic        [skf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic        [skf_pkg::DATA_W-1:0]     cfg_data
);
  import skf_pkg::*;

  skf_state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic             last_step;

  logic [DATA_W-1:0] q_r, r_r, p0_r;
  logic signed [DATA_W-1:0] est_r;
  logic [DATA_W-1:0] cov_r;
  logic              await_r;
  logic signed [DATA_W-1:0] meas_r;

  logic [DATA_W-1:0]        pred_r;
  logic signed [DEN_W-1:0]  diff_r;
  logic [GAIN_W-1:0]        gain_r;

  logic              in_accept, out_accept, done_go;
  skf_div_ctl_t      div_ctl;
  skf_mul_ctl_t      mul_ctl;

  logic [DATA_W:0]   pred_sum;
  logic [DATA_W-1:0] pred_c;
  logic [DEN_W-1:0]  den_c;
  logic signed [DEN_W-1:0] diff_c;
  logic [GAIN_W-1:0] quotient;

  logic signed [PROD_W-1:0] eprod, cprod;
  logic signed [PROD_W-16-1:0] delta;
  logic signed [PROD_W-16:0]   est_sum;
  logic signed [DATA_W-1:0]    est_new;
  logic [DATA_W:0]             cov_sum;
  logic [DATA_W-1:0]           cov_new;

  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_fv_r;
  logic [DATA_W-1:0]        out_cov_r;
  logic [GAIN_W-1:0]        out_gain_r;

  assign in_accept  = in_valid && !in_stall;
  assign out_accept = out_valid_r && !out_stall;
  assign done_go    = !out_valid_r || !out_stall;
  assign last_step  = (cnt_r == CNT_W'(STEPS - 1));

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_accept) state_nxt = S_PREP;
      S_PREP: state_nxt = S_DIV;
      S_DIV:  if (last_step) state_nxt = S_GAIN;
      S_GAIN: state_nxt = S_MUL;
      S_MUL:  if (last_step) state_nxt = S_DONE;
      S_DONE: if (done_go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_stall      = 1'b1;
    div_ctl       = '0;
    mul_ctl       = '0;
    unique case (state_r)
      S_IDLE: in_stall = 1'b0;
      S_PREP: div_ctl.load = 1'b1;
      S_DIV: begin
        div_ctl.step  = 1'b1;
        div_ctl.first = (cnt_r == '0);
      end
      S_GAIN: mul_ctl.load = 1'b1;
      S_MUL:  mul_ctl.step = 1'b1;
      S_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_DIV || state_r == S_MUL) begin
        cnt_r <= last_step ? '0 : cnt_r + 1'b1;
      end else begin
        cnt_r <= '0;
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r  <= RST_PROCESS_NOISE;
      r_r  <= RST_MEASUREMENT_NOISE;
      p0_r <= RST_INITIAL_COV;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PROCESS_NOISE:     q_r  <= cfg_data;
        REG_MEASUREMENT_NOISE: r_r  <= cfg_data;
        REG_INITIAL_COV:       p0_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Prediction, divisor and innovation
  always_comb begin
    pred_sum = {1'b0, cov_r} + {1'b0, q_r};
    pred_c   = pred_sum[DATA_W] ? '1 : pred_sum[DATA_W-1:0];
    den_c    = {1'b0, pred_c} + {1'b0, r_r};
    diff_c   = {meas_r[DATA_W-1], meas_r} - {est_r[DATA_W-1], est_r};
  end

  always_ff @(posedge clk) begin
    if (state_r == S_PREP) begin
      pred_r <= pred_c;
      diff_r <= diff_c;
    end
    if (state_r == S_GAIN) begin
      gain_r <= quotient;
    end
    if (in_accept) begin
      meas_r <= in_measurement;
    end
  end

  skf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .pred     (pred_c),
    .den      (den_c),
    .quotient (quotient)
  );

  skf_mul u_mul_est (
    .clk   (clk),
    .ctl   (mul_ctl),
    .mcand ({diff_r[DEN_W-1], diff_r}),
    .mult  (quotient),
    .prod  (eprod)
  );

  skf_mul u_mul_cov (
    .clk   (clk),
    .ctl   (mul_ctl),
    .mcand ({2'b00, pred_r}),
    .mult  (ONE_Q16 - quotient),
    .prod  (cprod)
  );

  // Round half up, correct the estimate and clamp; shrink the covariance
  always_comb begin
    delta   = eprod[PROD_W-1:16] + {{(PROD_W-17){1'b0}}, eprod[15]};
    est_sum = {{(PROD_W-16-DATA_W+1){est_r[DATA_W-1]}}, est_r} + {delta[PROD_W-17], delta};
    if (!est_sum[PROD_W-16] && (|est_sum[PROD_W-17:DATA_W-1])) begin
      est_new = {1'b0, {(DATA_W-1){1'b1}}};
    end else if (est_sum[PROD_W-16] && !(&est_sum[PROD_W-17:DATA_W-1])) begin
      est_new = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      est_new = est_sum[DATA_W-1:0];
    end
    cov_sum = cprod[DATA_W+16:16] + {{DATA_W{1'b0}}, cprod[15]};
    cov_new = cov_sum[DATA_W-1:0];
  end

  // Filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      est_r   <= '0;
      cov_r   <= '0;
      await_r <= 1'b1;
    end else if (in_accept && await_r) begin
      est_r   <= in_measurement;
      cov_r   <= p0_r;
      await_r <= 1'b0;
    end else if (state_r == S_DONE && done_go) begin
      est_r <= est_new;
      cov_r <= cov_new;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_DONE && done_go) begin
      out_valid_r <= 1'b1;
    end else if (out_accept) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE && done_go) begin
      out_fv_r   <= est_new;
      out_cov_r  <= cov_new;
      out_gain_r <= gain_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_filtered_value   = out_fv_r;
  assign out_error_covariance = out_cov_r;
  assign out_gain             = out_gain_r;

  `SKF_ASSERT_NOW(a_gain_at_most_one, clk, rst_n, out_valid_r,
    out_gain_r <= ONE_Q16, "gain above one")
  `SKF_ASSERT_NOW(a_cov_not_above_pred, clk, rst_n, state_r == S_DONE,
    cov_new <= pred_r, "updated covariance exceeds prediction")
  `SKF_ASSERT_NEXT(a_done_loads_output, clk, rst_n, state_r == S_DONE && done_go,
    out_valid_r && state_r == S_IDLE, "result not loaded on completion")
  `SKF_ASSERT_NOW(a_first_flag_cleared, clk, rst_n, state_r != S_IDLE,
    !await_r, "first-sample flag set during a transaction")

endmodule

`default_nettype wire

// ----- src/skf_div.sv -----
`default_nettype none

`include "scalar_kalman_filter_top_assert.svh"

// Restoring divider, one quotient bit per step, numerator = pred * 2^16.
module skf_div (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire skf_pkg::skf_div_ctl_t           ctl,
  input  wire logic [skf_pkg::DATA_W-1:0]      pred,
  input  wire logic [skf_pkg::DEN_W-1:0]       den,
  output logic      [skf_pkg::GAIN_W-1:0]      quotient
);
  import skf_pkg::*;

  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [DEN_W-1:0]  den_r;
  logic [GAIN_W-1:0] quo_r, quo_nxt;
  logic [REM_W-1:0]  trial;
  logic              ge;

  // First step compares the remainder as loaded, later steps shift in a zero
  always_comb begin
    trial   = ctl.first ? rem_r : {rem_r[REM_W-2:0], 1'b0};
    ge      = (trial >= {1'b0, den_r});
    rem_nxt = ge ? (trial - {1'b0, den_r}) : trial;
    quo_nxt = {quo_r[GAIN_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rem_r <= {{(REM_W-DATA_W){1'b0}}, pred};
      den_r <= den;
      quo_r <= '0;
    end else if (ctl.step) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  // Zero divisor gives zero gain
  assign quotient = (den_r == '0) ? '0 : quo_r;

  `SKF_ASSERT_NEXT(a_rem_below_den, clk, rst_n, ctl.step && !ctl.load,
    (rem_r < {1'b0, den_r}) || (den_r == '0), "divider remainder not below divisor")

endmodule

`default_nettype wire

// ----- src/skf_mul.sv -----
`default_nettype none

// Shift-add multiplier: signed multiplicand times unsigned 17-bit multiplier,
// one multiplier bit per step, LSB first.
module skf_mul (
  input  wire logic                               clk,
  input  wire skf_pkg::skf_mul_ctl_t              ctl,
  input  wire logic signed [skf_pkg::MC_W-1:0]    mcand,
  input  wire logic        [skf_pkg::GAIN_W-1:0]  mult,
  output logic signed      [skf_pkg::PROD_W-1:0]  prod
);
  import skf_pkg::*;

  logic signed [MC_W-1:0]   mc_r;
  logic        [GAIN_W-1:0] mr_r;
  logic signed [HI_W-1:0]   hi_r;
  logic        [GAIN_W-1:0] lo_r;
  logic signed [HI_W-1:0]   sum;

  // Add the multiplicand into the high half when the current bit is set
  always_comb begin
    sum = hi_r + (mr_r[0] ? {{(HI_W-MC_W){mc_r[MC_W-1]}}, mc_r} : '0);
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      mc_r <= mcand;
      mr_r <= mult;
      hi_r <= '0;
      lo_r <= '0;
    end else if (ctl.step) begin
      hi_r <= {sum[HI_W-1], sum[HI_W-1:1]};
      lo_r <= {sum[0], lo_r[GAIN_W-1:1]};
      mr_r <= {1'b0, mr_r[GAIN_W-1:1]};
    end
  end

  assign prod = {hi_r, lo_r};

endmodule

`default_nettype wire

// ----- test/tb.sv -----
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import skf_pkg::*;

  // Unused register slot; writes to it must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_ITEMS = 229;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic        [DATA_W-1:0] cov;
    logic        [GAIN_W-1:0] gain;
  } kf_result_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic signed [DATA_W-1:0]    in_measurement = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic signed [DATA_W-1:0]    out_filtered_value;
  logic        [DATA_W-1:0]    out_error_covariance;
  logic        [GAIN_W-1:0]    out_gain;
  logic                        cfg_we = 1'b0;
  logic        [CFG_IDX_W-1:0] cfg_index = '0;
  logic        [DATA_W-1:0]    cfg_data = '0;

  // Measurements waiting to be driven, results waiting to come out
  logic signed [DATA_W-1:0] meas_pending[$];
  kf_result_t               estimates_due[$];

  // Filter state and register copies kept by the predictor
  logic signed [DATA_W-1:0] est_q;
  logic        [DATA_W-1:0] cov_q;
  logic                     first_q;
  logic        [DATA_W-1:0] q_noise;
  logic        [DATA_W-1:0] r_noise;
  logic        [DATA_W-1:0] p_init;

  logic in_taken = 1'b0;
  int   drv_cycle = 0;
  int   fail_count = 0;
  logic idle_free;

  scalar_kalman_filter_top i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_measurement       (in_measurement),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_filtered_value   (out_filtered_value),
    .out_error_covariance (out_error_covariance),
    .out_gain             (out_gain),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Advance the filter by one measurement and return the expected result
  task automatic kf_predict(input logic signed [DATA_W-1:0] meas, output kf_result_t res);
    longint unsigned pred;
    longint unsigned den;
    longint unsigned k;
    longint          diff;
    longint          prod;
    longint          e;
    if (first_q) begin
      first_q = 1'b0;
      est_q   = meas;
      cov_q   = p_init;
    end
    pred = 64'(cov_q) + 64'(q_noise);
    if (pred > 64'hFFFF_FFFF) pred = 64'hFFFF_FFFF;
    den = pred + 64'(r_noise);
    k = (den == 0) ? 64'd0 : (pred << 16) / den;
    diff = longint'(meas) - longint'(est_q);
    prod = longint'(k) * diff;
    e = longint'(est_q) + ((prod + 64'sd32768) >>> 16);
    if (e > 64'sd2147483647) e = 64'sd2147483647;
    if (e < -64'sd2147483648) e = -64'sd2147483648;
    est_q = e[DATA_W-1:0];
    cov_q = 32'((((64'd65536 - k) * pred) + 64'd32768) >> 16);
    res.value = est_q;
    res.cov   = cov_q;
    res.gain  = k[GAIN_W-1:0];
  endtask

  // Track register writes, predict accepted measurements, check results
  always @(posedge clk) begin : monitor_b
    kf_result_t r;
    kf_result_t want;
    in_taken <= rst_n && in_valid && !in_stall;
    if (!rst_n) begin
      est_q   = '0;
      cov_q   = '0;
      first_q = 1'b1;
      q_noise = RST_PROCESS_NOISE;
      r_noise = RST_MEASUREMENT_NOISE;
      p_init  = RST_INITIAL_COV;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PROCESS_NOISE:     q_noise = cfg_data;
          REG_MEASUREMENT_NOISE: r_noise = cfg_data;
          REG_INITIAL_COV:       p_init  = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        kf_predict(in_measurement, r);
        estimates_due.push_back(r);
      end
      if (out_valid && !out_stall) begin
        if (estimates_due.size() == 0) begin
          $display("%0t unexpected result: expected none, got value %0d cov %0d gain %0d",
                   $time, out_filtered_value, out_error_covariance, out_gain);
          fail_count++;
        end else begin
          want = estimates_due.pop_front();
          if (out_filtered_value !== want.value) begin
            $display("%0t filtered_value mismatch: expected %0d, got %0d",
                     $time, want.value, out_filtered_value);
            fail_count++;
          end
          if (out_error_covariance !== want.cov) begin
            $display("%0t error_covariance mismatch: expected %0d, got %0d",
                     $time, want.cov, out_error_covariance);
            fail_count++;
          end
          if (out_gain !== want.gain) begin
            $display("%0t gain mismatch: expected %0d, got %0d",
                     $time, want.gain, out_gain);
            fail_count++;
          end
        end
      end
    end
  end

  // Recurring long stretch with no idling on either side
  assign idle_free = (drv_cycle % 5000) >= 3800;

  // Drive measurements and the result stall on the falling edge
  always @(negedge clk) begin
    drv_cycle <= drv_cycle + 1;
    if (!rst_n) begin
      in_valid  <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      out_stall <= !idle_free && ($urandom_range(99) < 29);
      if (!in_valid || in_taken) begin
        if (meas_pending.size() != 0 && (idle_free || $urandom_range(99) >= 29)) begin
          in_valid       <= 1'b1;
          in_measurement <= meas_pending.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_filter(input logic [DATA_W-1:0] q, input logic [DATA_W-1:0] r,
                            input logic [DATA_W-1:0] p0);
    write_reg(REG_PROCESS_NOISE, q);
    write_reg(REG_MEASUREMENT_NOISE, r);
    write_reg(REG_INITIAL_COV, p0);
  endtask

  // Hold until every measurement is out and checked, then let the block settle
  task automatic drain_filter();
    @(negedge clk);
    while (meas_pending.size() != 0 || in_valid || estimates_due.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [DATA_W-1:0] pick_noise();
    case ($urandom_range(5))
      0: return '0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(1, 2000);
      3: return $urandom_range(1 << 14, 1 << 20);
      4: return $urandom;
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  // Mostly a noisy slowly drifting signal, with jumps, extremes and raw noise
  function automatic logic [DATA_W-1:0] pick_measurement(inout longint level);
    int          mode;
    int          sh;
    longint      noise;
    longint      v;
    mode = $urandom_range(99);
    if (mode < 60) begin
      sh = $urandom_range(4, 24);
      level = level + longint'($urandom_range(0, 2000)) - 1000;
      noise = longint'($urandom & ((32'd1 << sh) - 1)) - (longint'(1) << (sh - 1));
      v = level + noise;
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return v[DATA_W-1:0];
    end else if (mode < 75) begin
      return $urandom;
    end else if (mode < 85) begin
      return 32'($signed(32'($urandom_range(0, 65536 * 8))) - 65536 * 4);
    end else if (mode < 92) begin
      case ($urandom_range(3))
        0: return 32'h7FFF_FFFF;
        1: return 32'h8000_0000;
        2: return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end else begin
      level = longint'($signed($urandom)) >>> $urandom_range(0, 16);
      return level[DATA_W-1:0];
    end
  endfunction

  initial begin : stimulus_b
    longint sig_level;
    sig_level = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // First sample with a zero denominator: gain stays zero throughout
    set_filter('0, '0, '0);
    meas_pending.push_back(32'h7FFF_FFFF);
    meas_pending.push_back(32'h8000_0000);
    meas_pending.push_back(32'h0000_0000);
    meas_pending.push_back(32'hFFFF_FFFF);
    drain_filter();

    // Saturating covariance prediction with full-scale swings
    set_filter(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    meas_pending.push_back(32'h8000_0000);
    meas_pending.push_back(32'h7FFF_FFFF);
    meas_pending.push_back(32'h8000_0000);
    meas_pending.push_back(32'h7FFF_FFFF);
    meas_pending.push_back(32'h0000_0001);
    meas_pending.push_back(32'h0000_0000);
    drain_filter();

    // Unity gain: the estimate follows the measurement
    set_filter(32'd1, '0, 32'd1);
    meas_pending.push_back(32'h1234_5678);
    meas_pending.push_back(-32'sd5);
    meas_pending.push_back(32'h4000_0000);
    drain_filter();

    // Back to reset defaults; the unused slot takes a write and is ignored
    set_filter(RST_PROCESS_NOISE, RST_MEASUREMENT_NOISE, RST_INITIAL_COV);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    meas_pending.push_back(32'h0001_0000);
    meas_pending.push_back(32'hFFFF_0000);
    meas_pending.push_back(32'h7FFF_FFFF);
    meas_pending.push_back(32'h8000_0000);
    meas_pending.push_back(32'h0000_0000);
    meas_pending.push_back(32'h0000_0001);
    meas_pending.push_back(32'hFFFF_FFFE);
    drain_filter();

    // Random phases, each under its own noise settings
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 7)
        set_filter('0, 32'hFFFF_FFFF, $urandom);
      else
        set_filter(pick_noise(), pick_noise(), pick_noise());
      if ($urandom_range(1)) write_reg(REG_UNUSED, $urandom);
      for (int n = 0; n < PHASE_ITEMS; n++)
        meas_pending.push_back(pick_measurement(sig_level));
      drain_filter();
    end

    if (fail_count == 0 && estimates_due.size() == 0) begin
      $display("scalar_kalman_filter_top regression: pass");
    end else begin
      $display("scalar_kalman_filter_top regression: fail");
    end
    $finish;
  end

  // Abort a hung run
  initial begin
    #6_000_000;
    $display("scalar_kalman_filter_top regression: fail");
    $finish;
  end

endmodule

`default_nettype wire
